/* sv/lnpk_pkg.sv */
// ----------------------------------------------------------------------------
// lnpk_pkg
// Shared types and constants for the last-note-priority key tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lnpk_pkg;

   localparam int DEF_NUM_QUEUES   = 2;
   localparam int DEF_NUM_CHANNELS = 16;
   localparam int DEF_NUM_KEYS     = 128;

   localparam logic [7:0] KEY_NONE = 8'hFF;
   localparam logic [6:0] KEY_MASK = 7'h7F;

   localparam logic MODE_ON  = 1'b0;
   localparam logic MODE_OFF = 1'b1;

   // One classified event as it travels from front to back.
   typedef struct packed {
      logic       in_range;
      logic       mode;
      logic       queue;
      logic [3:0] channel;
      logic [6:0] note;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_APP_CLR,
      ST_APP_LINK,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

/* sv/lnpk_front.sv */
// ----------------------------------------------------------------------------
// lnpk_front
// Accept events, check their indexes against the configured sizes and hold
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lnpk_front
   import lnpk_pkg::*;
#(
   parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int NUM_KEYS     = DEF_NUM_KEYS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_mode,
   input  wire logic       req_queue,
   input  wire logic [3:0] req_channel,
   input  wire logic [6:0] req_note,
   output      logic       item_valid,
   output      item_type   item,
   input  wire logic       item_pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   classified;

   // Classify: flag events whose indexes fall outside the configured sizes
   always_comb begin
      classified.in_range = (32'(req_queue) < NUM_QUEUES) &&
                            (32'(req_channel) < NUM_CHANNELS) &&
                            (32'(req_note) < NUM_KEYS);
      classified.mode     = req_mode;
      classified.queue    = req_queue;
      classified.channel  = req_channel;
      classified.note     = req_note & KEY_MASK;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the transaction payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

/* sv/lnpk_back.sv */
// ----------------------------------------------------------------------------
// lnpk_back
// Carry out one event: walk the slot's held-key list in the link memory,
// unlink the key, append it on note-on, update keys and counts, and present
// the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lnpk_back
   import lnpk_pkg::*;
#(
   parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int NUM_KEYS     = DEF_NUM_KEYS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   output      logic       item_pop,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_previous_key,
   output      logic [7:0] rsp_current_key,
   output      logic [7:0] rsp_last_key,
   output      logic [7:0] rsp_held_count,
   output      logic       rsp_note_was_held
);

   localparam int NUM_SLOTS  = NUM_QUEUES * NUM_CHANNELS;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int KEY_W      = $clog2(NUM_KEYS);
   localparam int QI_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int LINK_DEPTH = NUM_SLOTS << KEY_W;

   back_state_type state_ff, state_in;

   item_type          it_ff, it_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        at_ff, at_in;
   logic [7:0]        before_ff, before_in;
   logic              found_ff, found_in;

   logic [7:0] head_ff [NUM_SLOTS];
   logic [7:0] tail_ff [NUM_SLOTS];
   logic [7:0] cur_ff  [NUM_SLOTS];
   logic [7:0] last_ff [NUM_SLOTS];
   logic [7:0] cnt_ff  [NUM_QUEUES];

   logic [7:0] link_mem [LINK_DEPTH];
   logic [7:0] rd_data_ff;

   logic [SLOT_W-1:0]       slot_c;
   logic [QI_W-1:0]         q_idx;
   logic                    rsp_load;
   logic                    mem_we;
   logic [SLOT_W+KEY_W-1:0] mem_wr_addr;
   logic [7:0]              mem_wr_data;
   logic [SLOT_W+KEY_W-1:0] mem_rd_addr;
   logic                    head_we, tail_we;
   logic [7:0]              head_in, tail_in;
   logic                    at_match;
   logic [7:0]              cur_tail;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_prev_ff, rsp_cur_ff, rsp_last_ff, rsp_cnt_ff;
   logic [7:0] rsp_prev_in, rsp_cur_in, rsp_last_in, rsp_cnt_in;
   logic       rsp_held_ff, rsp_held_in;

   assign slot_c   = SLOT_W'(32'(item.queue) * NUM_CHANNELS + 32'(item.channel));
   assign q_idx    = QI_W'(it_ff.queue);
   assign at_match = (at_ff[6:0] == it_ff.note);
   assign cur_tail = tail_ff[slot_ff];
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign item_pop = (state_ff == ST_IDLE) && item_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (!item.in_range) begin
                  state_in = ST_DONE;
               end else if (head_ff[slot_c] != KEY_NONE) begin
                  state_in = ST_LOOK;
               end else begin
                  state_in = (item.mode == MODE_ON) ? ST_APP_CLR : ST_DONE;
               end
            end
         end
         ST_LOOK: begin
            if (at_match || rd_data_ff == KEY_NONE) begin
               state_in = (it_ff.mode == MODE_ON) ? ST_APP_CLR : ST_DONE;
            end
         end
         ST_APP_CLR:  state_in = ST_APP_LINK;
         ST_APP_LINK: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Walk, unlink and append controls
   always_comb begin
      it_in       = it_ff;
      slot_in     = slot_ff;
      at_in       = at_ff;
      before_in   = before_ff;
      found_in    = found_ff;
      mem_we      = 1'b0;
      mem_wr_addr = {slot_ff, it_ff.note[KEY_W-1:0]};
      mem_wr_data = KEY_NONE;
      mem_rd_addr = {slot_ff, at_ff[KEY_W-1:0]};
      head_we     = 1'b0;
      head_in     = KEY_NONE;
      tail_we     = 1'b0;
      tail_in     = KEY_NONE;
      case (state_ff)
         ST_IDLE: begin
            it_in       = item;
            slot_in     = slot_c;
            at_in       = head_ff[slot_c];
            before_in   = KEY_NONE;
            found_in    = 1'b0;
            mem_rd_addr = {slot_c, head_ff[slot_c][KEY_W-1:0]};
         end
         ST_LOOK: begin
            if (at_match) begin
               found_in = 1'b1;
               if (before_ff == KEY_NONE) begin
                  head_we = 1'b1;
                  head_in = rd_data_ff;
               end else begin
                  mem_we      = 1'b1;
                  mem_wr_addr = {slot_ff, before_ff[KEY_W-1:0]};
                  mem_wr_data = rd_data_ff;
               end
               if (cur_tail == at_ff) begin
                  tail_we = 1'b1;
                  tail_in = before_ff;
               end
            end else if (rd_data_ff != KEY_NONE) begin
               before_in   = at_ff;
               at_in       = rd_data_ff;
               mem_rd_addr = {slot_ff, rd_data_ff[KEY_W-1:0]};
            end
         end
         ST_APP_CLR: begin
            mem_we = 1'b1;
         end
         ST_APP_LINK: begin
            tail_we = 1'b1;
            tail_in = {1'b0, it_ff.note};
            if (cur_tail != KEY_NONE) begin
               mem_we      = 1'b1;
               mem_wr_addr = {slot_ff, cur_tail[KEY_W-1:0]};
               mem_wr_data = {1'b0, it_ff.note};
            end else begin
               head_we = 1'b1;
               head_in = {1'b0, it_ff.note};
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Result values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      rsp_prev_in = KEY_NONE;
      rsp_cur_in  = KEY_NONE;
      rsp_last_in = KEY_NONE;
      rsp_cnt_in  = 8'd0;
      rsp_held_in = 1'b0;
      if (it_ff.in_range) begin
         rsp_prev_in = cur_ff[slot_ff];
         rsp_held_in = found_ff;
         if (it_ff.mode == MODE_ON) begin
            rsp_cur_in  = {1'b0, it_ff.note};
            rsp_last_in = {1'b0, it_ff.note};
            rsp_cnt_in  = cnt_ff[q_idx] + 8'(!found_ff);
         end else begin
            rsp_cnt_in = cnt_ff[q_idx] - 8'(found_ff);
            if (cur_tail != KEY_NONE) begin
               rsp_cur_in  = cur_tail;
               rsp_last_in = cur_tail;
            end else begin
               rsp_cur_in  = {1'b0, it_ff.note};
               rsp_last_in = last_ff[slot_ff];
            end
         end
      end
   end

   // Control registers and per-slot list state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            head_ff[s] <= KEY_NONE;
            tail_ff[s] <= KEY_NONE;
            cur_ff[s]  <= KEY_NONE;
            last_ff[s] <= KEY_NONE;
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            cnt_ff[q] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_ff[slot_ff] <= head_in;
         end
         if (tail_we) begin
            tail_ff[slot_ff] <= tail_in;
         end
         if (rsp_load && it_ff.in_range) begin
            cur_ff[slot_ff]  <= rsp_cur_in;
            last_ff[slot_ff] <= rsp_last_in;
            cnt_ff[q_idx]    <= rsp_cnt_in;
         end
      end
   end

   // Hold the working item and result payload
   always_ff @(posedge clock) begin
      it_ff     <= it_in;
      slot_ff   <= slot_in;
      at_ff     <= at_in;
      before_ff <= before_in;
      found_ff  <= found_in;
      if (rsp_load) begin
         rsp_prev_ff <= rsp_prev_in;
         rsp_cur_ff  <= rsp_cur_in;
         rsp_last_ff <= rsp_last_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_held_ff <= rsp_held_in;
      end
   end

   // Link memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= link_mem[mem_rd_addr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_previous_key  = rsp_prev_ff;
   assign rsp_current_key   = rsp_cur_ff;
   assign rsp_last_key      = rsp_last_ff;
   assign rsp_held_count    = rsp_cnt_ff;
   assign rsp_note_was_held = rsp_held_ff;

endmodule

`default_nettype wire

/* sv/last_note_priority_key_tracker_top.sv */
// ----------------------------------------------------------------------------
// last_note_priority_key_tracker_top
// Last-note-priority key tracker: keeps the held keys of every queue and
// channel in press order and reports previous, current and last keys.
// ----------------------------------------------------------------------------
//  channel | ports  | direction | payload
//  --------+--------+-----------+--------------------------------------------
//  request | req_*  | in        | mode, queue, channel, note
//  result  | rsp_*  | out       | previous/current/last key, count, was held
//
//  An event visits the held keys of its slot's list (up to NUM_KEYS) one by
//  one through the link memory's single read port, then a note-on appends
//  its key at the tail of that list.
//  Reset clears list heads, tails and keys at once; the link memory needs no
//  clearing since only linked entries are ever read.
//  A two-entry queue takes requests while the back end works or the result
//  register waits on rsp_ready.
`default_nettype none

module last_note_priority_key_tracker_top
   import lnpk_pkg::*;
#(
   parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int NUM_KEYS     = DEF_NUM_KEYS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_mode,
   input  wire logic       req_queue,
   input  wire logic [3:0] req_channel,
   input  wire logic [6:0] req_note,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_previous_key,
   output      logic [7:0] rsp_current_key,
   output      logic [7:0] rsp_last_key,
   output      logic [7:0] rsp_held_count,
   output      logic       rsp_note_was_held
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   lnpk_front #(
      .NUM_QUEUES   (NUM_QUEUES),
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_KEYS     (NUM_KEYS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_queue   (req_queue),
      .req_channel (req_channel),
      .req_note    (req_note),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   lnpk_back #(
      .NUM_QUEUES   (NUM_QUEUES),
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_KEYS     (NUM_KEYS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_previous_key  (rsp_previous_key),
      .rsp_current_key   (rsp_current_key),
      .rsp_last_key      (rsp_last_key),
      .rsp_held_count    (rsp_held_count),
      .rsp_note_was_held (rsp_note_was_held)
   );

   // The back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("pop from empty event queue");

   // A full queue always offers an item to the back end
   a_full_offers: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> item_valid)
      else $error("queue refuses input while empty");

   // A held note always leaves a real current key
   a_held_has_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_note_was_held |-> rsp_current_key != KEY_NONE)
      else $error("held note reported without current key");

endmodule

`default_nettype wire

/* tb/last_note_priority_key_tracker_checker.sv */
// ----------------------------------------------------------------------------
// last_note_priority_key_tracker_checker
// Watches the request and result channels, predicts the key tracker's
// response per accepted transaction and compares every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module last_note_priority_key_tracker_checker
   import lnpk_pkg::*;
#(
   parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int NUM_KEYS     = DEF_NUM_KEYS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_mode,
   input  logic       req_queue,
   input  logic [3:0] req_channel,
   input  logic [6:0] req_note,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_previous_key,
   input  logic [7:0] rsp_current_key,
   input  logic [7:0] rsp_last_key,
   input  logic [7:0] rsp_held_count,
   input  logic       rsp_note_was_held,
   output int         fail_count,
   output int         pending_count,
   output int         result_count
);

   localparam int NUM_SLOTS = NUM_QUEUES * NUM_CHANNELS;

   typedef struct {
      logic [7:0] previous_key;
      logic [7:0] current_key;
      logic [7:0] latest_key;
      logic [7:0] held_count;
      logic       note_was_held;
   } key_report_type;

   // Held keys of each slot in press order, oldest first
   int unsigned    press_order[NUM_SLOTS][$];
   logic [7:0]     prev_key_of[NUM_SLOTS];
   logic [7:0]     cur_key_of[NUM_SLOTS];
   logic [7:0]     latest_key_of[NUM_SLOTS];
   logic [7:0]     queue_held[NUM_QUEUES];
   key_report_type awaited_reports[$];

   function automatic key_report_type track_event(logic mode, int unsigned queue,
                                                 int unsigned channel,
                                                 int unsigned note);
      key_report_type r;
      int unsigned    slot;
      bit             held;
      held = 0;
      if (queue >= NUM_QUEUES || channel >= NUM_CHANNELS || note >= NUM_KEYS) begin
         r = '{KEY_NONE, KEY_NONE, KEY_NONE, 8'd0, 1'b0};
         return r;
      end
      slot = queue * NUM_CHANNELS + channel;
      prev_key_of[slot] = cur_key_of[slot];
      cur_key_of[slot] = note[7:0];
      // Drop the key from its place in the order
      for (int i = 0; i < press_order[slot].size(); i++) begin
         if (press_order[slot][i] == note) begin
            press_order[slot].delete(i);
            held = 1;
            break;
         end
      end
      if (mode == MODE_ON) begin
         press_order[slot].push_back(note);
         latest_key_of[slot] = note[7:0];
         if (!held) queue_held[queue] = queue_held[queue] + 8'd1;
      end else begin
         if (held) queue_held[queue] = queue_held[queue] - 8'd1;
         if (press_order[slot].size() > 0) begin
            cur_key_of[slot] = 8'(press_order[slot][$]);
            latest_key_of[slot] = 8'(press_order[slot][$]);
         end
      end
      r = '{prev_key_of[slot], cur_key_of[slot], latest_key_of[slot],
            queue_held[queue], held};
      return r;
   endfunction

   task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   assign pending_count = awaited_reports.size();

   always @(posedge clock) begin
      key_report_type want;
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            press_order[s].delete();
            prev_key_of[s] = KEY_NONE;
            cur_key_of[s] = KEY_NONE;
            latest_key_of[s] = KEY_NONE;
         end
         for (int q = 0; q < NUM_QUEUES; q++) queue_held[q] = 8'd0;
         awaited_reports.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         // Check the result before predicting, so a same-edge request cannot race it
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (awaited_reports.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fail_count++;
            end else begin
               want = awaited_reports.pop_front();
               compare_field("previous_key", want.previous_key, rsp_previous_key);
               compare_field("current_key", want.current_key, rsp_current_key);
               compare_field("latest_key", want.latest_key, rsp_last_key);
               compare_field("held_count", want.held_count, rsp_held_count);
               compare_field("note_was_held", {7'd0, want.note_was_held},
                             {7'd0, rsp_note_was_held});
            end
         end
         if (req_valid && req_ready)
            awaited_reports.push_back(track_event(req_mode, 32'(req_queue),
                                                  32'(req_channel), 32'(req_note)));
      end
   end

endmodule

/* tb/last_note_priority_key_tracker_top_test.sv */
// ----------------------------------------------------------------------------
// last_note_priority_key_tracker_top_test
// Drives note-on and note-off events into the key tracker through directed
// and random phases with sender gaps and receiver stalls; the checker
// predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module last_note_priority_key_tracker_top_test;
   import lnpk_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic       req_queue;
   logic [3:0] req_channel;
   logic [6:0] req_note;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_previous_key;
   logic [7:0] rsp_current_key;
   logic [7:0] rsp_last_key;
   logic [7:0] rsp_held_count;
   logic       rsp_note_was_held;
   int         fail_count;
   int         pending_count;
   int         result_count;

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_off;
   int idle_cycles;
   int event_count;

   last_note_priority_key_tracker_top dut (.*);

   last_note_priority_key_tracker_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: count cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one event and hold it until accepted; drop valid only in idle gaps
   task automatic send_event(logic mode, logic queue, logic [3:0] channel,
                             logic [6:0] note);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_queue   <= queue;
      req_channel <= channel;
      req_note    <= note;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      event_count++;
   endtask

   // Press a few keys on one slot, repress and release some, then let go
   task automatic send_phrase();
      logic       queue;
      logic [3:0] channel;
      logic [6:0] keys[$];
      int         n;
      queue   = 1'($urandom_range(1));
      channel = 4'($urandom_range(15));
      n       = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         keys.push_back(7'($urandom_range(127)));
         send_event(MODE_ON, queue, channel, keys[i]);
      end
      if ($urandom_range(1)) send_event(MODE_ON, queue, channel, keys[$urandom_range(n - 1)]);
      keys.shuffle();
      for (int i = 0; i < n; i++)
         if ($urandom_range(9) != 0) send_event(MODE_OFF, queue, channel, keys[i]);
   endtask

   task automatic run_random(int count);
      int start;
      start = event_count;
      while (event_count - start < count) begin
         if ($urandom_range(9) < 8)
            send_phrase();
         else
            send_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                       4'($urandom_range(15)), 7'($urandom_range(127)));
      end
   endtask

   initial begin
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off = 1'b0;
      event_count = 0;
      idle_cycles = 0;
      req_valid = 1'b0;
      req_mode = MODE_ON;
      req_queue = 1'b0;
      req_channel = 4'd0;
      req_note = 7'd0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, head represses, stray and final release
      send_event(MODE_OFF, 1'b0, 4'd0, 7'd0);
      send_event(MODE_ON, 1'b0, 4'd0, 7'd0);
      send_event(MODE_ON, 1'b0, 4'd0, 7'd127);
      send_event(MODE_ON, 1'b0, 4'd0, 7'd64);
      send_event(MODE_ON, 1'b0, 4'd0, 7'd0);
      send_event(MODE_ON, 1'b0, 4'd0, 7'd127);
      send_event(MODE_OFF, 1'b0, 4'd0, 7'd127);
      send_event(MODE_OFF, 1'b0, 4'd0, 7'd5);
      send_event(MODE_OFF, 1'b0, 4'd0, 7'd64);
      send_event(MODE_OFF, 1'b0, 4'd0, 7'd0);
      send_event(MODE_ON, 1'b1, 4'd15, 7'd127);
      send_event(MODE_ON, 1'b1, 4'd15, 7'd85);
      send_event(MODE_OFF, 1'b1, 4'd15, 7'd85);
      send_event(MODE_OFF, 1'b1, 4'd15, 7'd127);
      send_event(MODE_ON, 1'b1, 4'd10, 7'd42);

      // Random phases with different idling, then a long receiver hold-off
      run_random(120);
      sender_idle_pct = 48;
      run_random(200);
      sender_idle_pct = 0;
      receiver_stall_pct = 48;
      run_random(200);
      sender_idle_pct = 36;
      receiver_stall_pct = 36;
      run_random(200);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         run_random(40);
      join
      // Wrap the held count on queue 0 by pressing many distinct keys
      for (int c = 0; c < 3; c++)
         for (int k = 0; k < 128; k++)
            if (c < 2 || k < 20) send_event(MODE_ON, 1'b0, c[3:0], k[6:0]);
      for (int k = 0; k < 20; k++) send_event(MODE_OFF, 1'b0, 4'd2, k[6:0]);
      run_random(100);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d events and %0d results across idling phases,", event_count,
               result_count);
      $display("including repress, stray release and held count wrap.");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
